// File: hdl/rbfk_pkg.sv
// ----------------------------------------------------------------------------
// rbfk_pkg
// Shared types, constants and the power-of-two table of the RBF kernel block.
// ----------------------------------------------------------------------------
package rbfk_pkg;

    localparam int LANES      = 4;
    localparam int SUM_W      = 48;
    localparam int GAMMA_W    = 16;
    localparam int KV_W       = 16;
    localparam int CNT_W      = 3;
    localparam int TAB_W      = 17;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;
    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [15:0]        LOG2E_Q15   = 16'd47274;
    localparam logic [20:0]        T_LIMIT     = 21'(12 << 16);
    localparam logic [KV_W-1:0]    KV_MAX      = {KV_W{1'b1}};

    // distance handed from the accumulator to the exponential tail
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sq_dist;
        logic             sat;
    } t_dist_req;

    // round(65536 * 2^(-k/16))
    function automatic logic [TAB_W-1:0] pow2_neg(input logic [4:0] k);
        logic [TAB_W-1:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/rbfk_lane.sv
// ----------------------------------------------------------------------------
// rbfk_lane
// One feature lane: squared difference of a feature pair, zero when disabled.
// ----------------------------------------------------------------------------
module rbfk_lane #(
    parameter int FEATURE_WIDTH = 16
) (
    input  logic signed [FEATURE_WIDTH-1:0] i_x,
    input  logic signed [FEATURE_WIDTH-1:0] i_y,
    input  logic                            i_en,
    output logic [2*FEATURE_WIDTH-1:0]      o_sq
);

    localparam int DW = FEATURE_WIDTH + 1;

    logic signed [DW-1:0]            w_d;
    logic [FEATURE_WIDTH-1:0]        w_m;

    assign w_d = DW'(i_x) - DW'(i_y);

    always_comb begin
        if (w_d[DW-1]) begin
            w_m = FEATURE_WIDTH'(-w_d);
        end else begin
            w_m = FEATURE_WIDTH'(w_d);
        end
    end

    assign o_sq = i_en ? ((2*FEATURE_WIDTH)'(w_m) * (2*FEATURE_WIDTH)'(w_m))
                       : '0;

endmodule

// File: hdl/rbfk_merge.sv
// ----------------------------------------------------------------------------
// rbfk_merge
// Registers the lane squares, sums them and adds the total to the saturating
// distance accumulator; hands the final distance on the last group.
// ----------------------------------------------------------------------------
module rbfk_merge #(
    parameter int SQ_W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_last,
    input  logic [SQ_W-1:0]       i_sq [rbfk_pkg::LANES],
    output logic                  o_pending,
    output rbfk_pkg::t_dist_req   o_req
);

    localparam int TOT_W = SQ_W + $clog2(rbfk_pkg::LANES);
    localparam int EXT_W = ((TOT_W > rbfk_pkg::SUM_W) ? TOT_W : rbfk_pkg::SUM_W) + 1;

    logic [SQ_W-1:0]            r_sq [rbfk_pkg::LANES];
    logic                       r_s1_valid;
    logic                       r_s1_last;
    logic [rbfk_pkg::SUM_W-1:0] r_acc;
    logic                       r_sat;

    logic [TOT_W-1:0]           w_tot;
    logic [EXT_W-1:0]           w_next;
    logic                       w_over;
    logic [rbfk_pkg::SUM_W-1:0] n_acc;
    logic                       n_sat;

    always_comb begin
        w_tot = '0;
        for (int k = 0; k < rbfk_pkg::LANES; k++) begin
            w_tot = w_tot + TOT_W'(r_sq[k]);
        end
    end

    assign w_next = EXT_W'(r_acc) + EXT_W'(w_tot);
    assign w_over = w_next > EXT_W'(rbfk_pkg::SUM_MAX);
    assign n_acc  = w_over ? rbfk_pkg::SUM_MAX : rbfk_pkg::SUM_W'(w_next);
    assign n_sat  = r_sat | w_over;

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int k = 0; k < rbfk_pkg::LANES; k++) begin
                r_sq[k] <= i_sq[k];
            end
            r_s1_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_acc      <= '0;
            r_sat      <= 1'b0;
        end else begin
            r_s1_valid <= i_fire;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_acc <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_acc <= n_acc;
                    r_sat <= n_sat;
                end
            end
        end
    end

    assign o_pending     = r_s1_valid & r_s1_last;
    assign o_req.valid   = r_s1_valid & r_s1_last;
    assign o_req.sq_dist = n_acc;
    assign o_req.sat     = n_sat;

endmodule

// File: hdl/rbfk_exp.sv
// ----------------------------------------------------------------------------
// rbfk_exp
// Kernel tail: 2^(-gamma*dist*log2 e) through three multiply steps, table
// interpolation and the output register.
// ----------------------------------------------------------------------------
module rbfk_exp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [rbfk_pkg::GAMMA_W-1:0]    i_gamma,
    input  rbfk_pkg::t_dist_req             i_req,
    input  logic                            i_out_ready,
    output logic                            o_busy,
    output logic                            o_out_valid,
    output logic [rbfk_pkg::KV_W-1:0]       o_kernel_value,
    output logic [rbfk_pkg::SUM_W-1:0]      o_squared_distance,
    output logic                            o_distance_saturated
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MULA = 5'b00010,
        ST_MULB = 5'b00100,
        ST_INTP = 5'b01000,
        ST_DONE = 5'b10000
    } t_exp_state;

    t_exp_state r_state, n_state;

    logic [rbfk_pkg::SUM_W-1:0] r_dist;
    logic                       r_sat;
    logic [47:0]                r_prod;
    logic                       r_big;
    logic [35:0]                r_t36;
    logic                       r_zero;
    logic [rbfk_pkg::TAB_W-1:0] r_ti;
    logic [23:0]                r_dif;
    logic [3:0]                 r_n;
    logic                       r_out_valid;
    logic [rbfk_pkg::KV_W-1:0]  r_kv;
    logic [rbfk_pkg::SUM_W-1:0] r_out_dist;
    logic                       r_out_sat;

    logic [20:0]                w_t;
    logic                       w_zero;
    logic [4:0]                 w_i;
    logic [rbfk_pkg::TAB_W-1:0] w_ti;
    logic [rbfk_pkg::TAB_W-1:0] w_ti1;
    logic [11:0]                w_step;
    logic [rbfk_pkg::TAB_W-1:0] w_v;
    logic [rbfk_pkg::TAB_W-1:0] w_sh;
    logic [rbfk_pkg::KV_W-1:0]  w_kv;
    logic                       w_load;

    assign w_t    = r_t36[35:15];
    assign w_zero = r_zero || (w_t >= rbfk_pkg::T_LIMIT);
    assign w_i    = {1'b0, w_t[15:12]};
    assign w_ti   = rbfk_pkg::pow2_neg(w_i);
    assign w_ti1  = rbfk_pkg::pow2_neg(w_i + 5'd1);
    assign w_step = 12'(w_ti - w_ti1);

    assign w_v  = r_ti - rbfk_pkg::TAB_W'(r_dif[23:12]);
    assign w_sh = w_v >> r_n;
    always_comb begin
        if (r_zero) begin
            w_kv = '0;
        end else if (w_sh > rbfk_pkg::TAB_W'(rbfk_pkg::KV_MAX)) begin
            w_kv = rbfk_pkg::KV_MAX;
        end else begin
            w_kv = rbfk_pkg::KV_W'(w_sh);
        end
    end

    assign w_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = i_req.valid ? ST_MULA : ST_IDLE;
            ST_MULA: n_state = ST_MULB;
            ST_MULB: n_state = ST_INTP;
            ST_INTP: n_state = ST_DONE;
            ST_DONE: n_state = w_load ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_dist <= i_req.sq_dist;
                r_sat  <= i_req.sat;
            end
            ST_MULA: begin
                r_prod <= 48'(i_gamma) * 48'(r_dist[31:0]);
                r_big  <= (r_dist[47:32] != '0) && (i_gamma != '0);
            end
            ST_MULB: begin
                r_t36  <= 36'(r_prod[31:12]) * 36'(rbfk_pkg::LOG2E_Q15);
                r_zero <= r_big || (r_prod[47:32] != '0);
            end
            ST_INTP: begin
                r_ti   <= w_ti;
                r_dif  <= 24'(w_step) * 24'(w_t[11:0]);
                r_n    <= w_t[19:16];
                r_zero <= w_zero;
            end
            ST_DONE: begin
                if (w_load) begin
                    r_kv       <= w_kv;
                    r_out_dist <= r_dist;
                    r_out_sat  <= r_sat;
                end
            end
            default: begin
                r_sat <= r_sat;
            end
        endcase
    end

    assign o_busy               = (r_state != ST_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_kernel_value       = r_kv;
    assign o_squared_distance   = r_out_dist;
    assign o_distance_saturated = r_out_sat;

endmodule

// File: hdl/rbf_kernel_value.sv
// ----------------------------------------------------------------------------
// rbf_kernel_value
// Gaussian RBF kernel exp(-gamma*||x-y||^2) over groups of four feature pairs.
// ----------------------------------------------------------------------------
// Groups that are not the last of a vector pair are taken one per cycle while
// the tail is idle: four lanes square the differences at the input and the
// merge stage adds them to the 48-bit saturating accumulator in the next
// cycle. A last group closes the vector pair and hands the distance to the
// exponential tail (gamma multiply, log2 e multiply, interpolation multiply,
// clamp); the input stays not ready until the tail has loaded the output
// register, and longer if a previous result still waits there.
module rbf_kernel_value #(
    parameter int FEATURE_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbfk_pkg::GAMMA_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [FEATURE_WIDTH-1:0]   i_x_a,
    input  logic signed [FEATURE_WIDTH-1:0]   i_x_b,
    input  logic signed [FEATURE_WIDTH-1:0]   i_x_c,
    input  logic signed [FEATURE_WIDTH-1:0]   i_x_d,
    input  logic signed [FEATURE_WIDTH-1:0]   i_y_a,
    input  logic signed [FEATURE_WIDTH-1:0]   i_y_b,
    input  logic signed [FEATURE_WIDTH-1:0]   i_y_c,
    input  logic signed [FEATURE_WIDTH-1:0]   i_y_d,
    input  logic [rbfk_pkg::CNT_W-1:0]        i_valid_pairs,
    input  logic                              i_last_group,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rbfk_pkg::KV_W-1:0]         o_kernel_value,
    output logic [rbfk_pkg::SUM_W-1:0]        o_squared_distance,
    output logic                              o_distance_saturated
);

    localparam int SQ_W = 2 * FEATURE_WIDTH;

    logic [rbfk_pkg::GAMMA_W-1:0]    r_gamma;
    logic signed [FEATURE_WIDTH-1:0] w_x [rbfk_pkg::LANES];
    logic signed [FEATURE_WIDTH-1:0] w_y [rbfk_pkg::LANES];
    logic [SQ_W-1:0]                 w_sq [rbfk_pkg::LANES];
    logic                            w_fire;
    logic                            w_pending;
    logic                            w_busy;
    rbfk_pkg::t_dist_req             w_req;

    assign w_x[0] = i_x_a;
    assign w_x[1] = i_x_b;
    assign w_x[2] = i_x_c;
    assign w_x[3] = i_x_d;
    assign w_y[0] = i_y_a;
    assign w_y[1] = i_y_b;
    assign w_y[2] = i_y_c;
    assign w_y[3] = i_y_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= rbfk_pkg::GAMMA_RESET;
        end else if (i_cfg_valid) begin
            r_gamma <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !w_pending && !w_busy;
    assign w_fire      = i_in_valid && o_in_ready;

    for (genvar g = 0; g < rbfk_pkg::LANES; g++) begin : g_lane
        rbfk_lane #(
            .FEATURE_WIDTH(FEATURE_WIDTH)
        ) u_lane (
            .i_x  (w_x[g]),
            .i_y  (w_y[g]),
            .i_en (32'(i_valid_pairs) > g),
            .o_sq (w_sq[g])
        );
    end

    rbfk_merge #(
        .SQ_W(SQ_W)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_last    (i_last_group),
        .i_sq      (w_sq),
        .o_pending (w_pending),
        .o_req     (w_req)
    );

    rbfk_exp u_exp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_gamma              (r_gamma),
        .i_req                (w_req),
        .i_out_ready          (i_out_ready),
        .o_busy               (w_busy),
        .o_out_valid          (o_out_valid),
        .o_kernel_value       (o_kernel_value),
        .o_squared_distance   (o_squared_distance),
        .o_distance_saturated (o_distance_saturated)
    );

endmodule

// File: hdl/rbfk_checker.sv
// ----------------------------------------------------------------------------
// rbfk_checker
// Port-level checks of the RBF kernel block, bound to the top level.
// ----------------------------------------------------------------------------
module rbfk_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [rbfk_pkg::KV_W-1:0]     o_kernel_value,
    input logic [rbfk_pkg::SUM_W-1:0]    o_squared_distance,
    input logic                          o_distance_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_kernel_value)
                                       && $stable(o_squared_distance))
        else $error("stalled result changed");

    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_distance_saturated |-> (&o_squared_distance))
        else $error("saturated distance not at full scale");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_squared_distance == '0) |-> (&o_kernel_value))
        else $error("zero distance does not give full-scale kernel");

endmodule

bind rbf_kernel_value rbfk_checker u_rbfk_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_kernel_value       (o_kernel_value),
    .o_squared_distance   (o_squared_distance),
    .o_distance_saturated (o_distance_saturated)
);
